FILE: src/mrp_pkg.sv
package mrp_pkg;

  localparam int MaxLinesDefault = 128;
  localparam int LineSizeDefault = 128;

  localparam logic [7:0] ChCr    = 8'h0D;
  localparam logic [7:0] ChLf    = 8'h0A;
  localparam logic [7:0] ChQuote = 8'd34;
  localparam logic [7:0] ChSpace = 8'd32;
  localparam logic [7:0] ChLast  = 8'd126;
  localparam logic [7:0] ChO     = 8'h4F;
  localparam logic [7:0] ChK     = 8'h4B;
  localparam logic [7:0] ChE     = 8'h45;
  localparam logic [7:0] ChR     = 8'h52;
  localparam logic [7:0] ChPlus  = 8'h2B;

  localparam logic [1:0] ModePlus = 2'd0;
  localparam logic [1:0] ModeFree = 2'd1;
  localparam logic [1:0] ModeSms  = 2'd2;

  localparam logic [1:0] StatusPending  = 2'd0;
  localparam logic [1:0] StatusComplete = 2'd1;
  localparam logic [1:0] StatusError    = 2'd2;

  localparam logic [1:0] OutcomeError    = 2'd0;
  localparam logic [1:0] OutcomeOk       = 2'd1;
  localparam logic [1:0] OutcomeProgress = 2'd2;

  localparam logic [1:0] StoreNone  = 2'd0;
  localparam logic [1:0] StoreOne   = 2'd1;
  localparam logic [1:0] StoreSpace = 2'd2;

  typedef enum logic [27:0] {
    ST_WAIT         = 28'h0000001,
    ST_LEAD_LF      = 28'h0000002,
    ST_LINE_START   = 28'h0000004,
    ST_O            = 28'h0000008,
    ST_E            = 28'h0000010,
    ST_PLUS         = 28'h0000020,
    ST_OK           = 28'h0000040,
    ST_OK_CR        = 28'h0000080,
    ST_ER           = 28'h0000100,
    ST_ERR          = 28'h0000200,
    ST_ERRO         = 28'h0000400,
    ST_ERROR        = 28'h0000800,
    ST_ERROR_CR     = 28'h0001000,
    ST_PLUS_TEXT    = 28'h0002000,
    ST_PLUS_LF      = 28'h0004000,
    ST_PLUS_NEXT    = 28'h0008000,
    ST_BLANK_LF     = 28'h0010000,
    ST_BLANK_END    = 28'h0020000,
    ST_FREE_TEXT    = 28'h0040000,
    ST_FREE_LF      = 28'h0080000,
    ST_FREE_NEXT    = 28'h0100000,
    ST_FREE_CR_LF   = 28'h0200000,
    ST_FREE_END     = 28'h0400000,
    ST_SMS_TEXT     = 28'h0800000,
    ST_SMS_LF       = 28'h1000000,
    ST_SMS_NEXT     = 28'h2000000,
    ST_SMS_CR_LF    = 28'h4000000,
    ST_SMS_END      = 28'h8000000
  } state_t;

  typedef struct packed {
    logic [1:0] parse_status;
    logic [1:0] reply_outcome;
    logic [7:0] lines_stored;
    logic [1:0] store_count;
    logic [6:0] store_line;
    logic [6:0] store_column;
    logic [7:0] store_char;
  } result_t;

  function automatic logic is_printable(input logic [7:0] c);
    return (c >= ChSpace) && (c <= ChLast);
  endfunction

  function automatic logic [7:0] sat_inc(input logic [7:0] v);
    return (v == 8'hFF) ? v : v + 8'd1;
  endfunction

endpackage

FILE: src/modem_response_parser.sv
// Byte-serial parser for a modem reply: CR LF, optional text lines, then
// OK or ERROR with CR LF. The text line syntax follows the mode register.
// The input channel (in_valid, in_stall, rx_byte) takes one byte per
// transfer. Each byte yields exactly one result on the output channel
// (out_valid, out_stall and the result fields): the parse status, the
// outcome, the completed line count and a write command for the line table.
// Each result is registered in the output register or the second entry. The
// block takes one byte per cycle while in_stall is low; next state and write
// decode is combinational between the parser state and output registers.
// A second output entry holds one more result, so a byte is still taken
// while a result waits; in_stall rises only once both entries are full and
// the receiver stalls, and falls again at the edge of the next output transfer.
// The user must write the mode register through cfg_write and cfg_data only while idle; the block does not enforce it.
// Synchronous reset puts the parser in the waiting state with outcome in
// progress, clears the line count, cursor and mode, and empties the output.
module modem_response_parser #(
  parameter int MAX_LINES = mrp_pkg::MaxLinesDefault,
  parameter int LINE_SIZE = mrp_pkg::LineSizeDefault
) (
  input  logic       clk,
  input  logic       rst,
  input  logic       cfg_write,
  input  logic [1:0] cfg_data,
  input  logic       in_valid,
  output logic       in_stall,
  input  logic [7:0] rx_byte,
  output logic       out_valid,
  input  logic       out_stall,
  output logic [1:0] parse_status,
  output logic [1:0] reply_outcome,
  output logic [7:0] lines_stored,
  output logic [1:0] store_count,
  output logic [6:0] store_line,
  output logic [6:0] store_column,
  output logic [7:0] store_char
);

  import mrp_pkg::*;

  localparam logic [8:0] MaxLinesW = 9'(MAX_LINES);
  localparam logic [8:0] LineSizeW = 9'(LINE_SIZE);

  logic [1:0] reply_mode;
  state_t     state;
  state_t     state_next;
  logic [7:0] cursor;
  logic [7:0] cursor_next;
  logic [7:0] text_lines;
  logic [7:0] text_lines_next;
  logic [1:0] outcome;
  logic [1:0] outcome_next;

  result_t    res;
  result_t    out_reg;
  result_t    skid_reg;
  logic       skid_valid;
  logic       push;
  logic       pop;

  logic       put_en;
  logic       put_space;
  logic [7:0] put_c;
  logic [7:0] cur_base;
  logic [7:0] lc_base;
  logic       err;

  assign push     = in_valid && !in_stall;
  assign pop      = out_valid && !out_stall;
  assign in_stall = skid_valid;

  always_comb begin
    err          = 1'b0;
    state_next   = state;
    outcome_next = outcome;
    lc_base      = text_lines;
    cur_base     = cursor;
    put_en       = 1'b0;
    put_space    = 1'b0;
    put_c        = rx_byte;
    res          = '0;
    res.parse_status = StatusPending;

    case (state)
      ST_WAIT: begin
        outcome_next = OutcomeProgress;
        lc_base      = 8'd0;
        cur_base     = 8'd0;
        if (rx_byte == ChCr) state_next = ST_LEAD_LF;
        else err = 1'b1;
      end
      ST_LEAD_LF: begin
        if (rx_byte == ChLf) state_next = ST_LINE_START;
        else err = 1'b1;
      end
      ST_PLUS_LF: begin
        if (rx_byte == ChLf) state_next = ST_PLUS_NEXT;
        else err = 1'b1;
      end
      ST_BLANK_LF: begin
        if (rx_byte == ChLf) state_next = ST_BLANK_END;
        else err = 1'b1;
      end
      ST_FREE_LF: begin
        if (rx_byte == ChLf) state_next = ST_FREE_NEXT;
        else err = 1'b1;
      end
      ST_FREE_CR_LF: begin
        if (rx_byte == ChLf) state_next = ST_FREE_END;
        else err = 1'b1;
      end
      ST_SMS_LF: begin
        if (rx_byte == ChLf) state_next = ST_SMS_NEXT;
        else err = 1'b1;
      end
      ST_SMS_CR_LF: begin
        if (rx_byte == ChLf) state_next = ST_SMS_END;
        else err = 1'b1;
      end
      ST_LINE_START: begin
        if (rx_byte == ChO) state_next = ST_O;
        else if (rx_byte == ChE) state_next = ST_E;
        else if (rx_byte == ChPlus && (reply_mode == ModePlus || reply_mode == ModeSms))
          state_next = ST_PLUS;
        else if (reply_mode == ModeFree && is_printable(rx_byte)) begin
          put_en     = 1'b1;
          state_next = ST_FREE_TEXT;
        end else err = 1'b1;
      end
      ST_O: begin
        if (rx_byte == ChK) state_next = ST_OK;
        else err = 1'b1;
      end
      ST_E: begin
        if (rx_byte == ChR) state_next = ST_ER;
        else err = 1'b1;
      end
      ST_PLUS: begin
        if (is_printable(rx_byte)) begin
          put_en     = 1'b1;
          state_next = ST_PLUS_TEXT;
        end else err = 1'b1;
      end
      ST_OK: begin
        if (rx_byte == ChCr) state_next = ST_OK_CR;
        else err = 1'b1;
      end
      ST_OK_CR: begin
        state_next = ST_WAIT;
        if (rx_byte == ChLf) begin
          cur_base         = 8'd0;
          outcome_next     = OutcomeOk;
          res.parse_status = StatusComplete;
        end else begin
          outcome_next     = OutcomeError;
          res.parse_status = StatusError;
        end
      end
      ST_ER: begin
        if (rx_byte == ChR) state_next = ST_ERR;
        else err = 1'b1;
      end
      ST_ERR: begin
        if (rx_byte == ChO) state_next = ST_ERRO;
        else err = 1'b1;
      end
      ST_ERRO: begin
        if (rx_byte == ChR) state_next = ST_ERROR;
        else err = 1'b1;
      end
      ST_ERROR: begin
        if (rx_byte == ChCr) state_next = ST_ERROR_CR;
        else err = 1'b1;
      end
      ST_ERROR_CR: begin
        if (rx_byte == ChLf) begin
          state_next       = ST_WAIT;
          cur_base         = 8'd0;
          outcome_next     = OutcomeError;
          res.parse_status = StatusComplete;
        end else err = 1'b1;
      end
      ST_PLUS_TEXT, ST_FREE_TEXT: begin
        if (is_printable(rx_byte)) begin
          put_en    = 1'b1;
          put_space = (state == ST_PLUS_TEXT) && (reply_mode == ModeSms)
                      && (rx_byte == ChQuote);
        end else if (rx_byte == ChCr) begin
          lc_base    = sat_inc(text_lines);
          cur_base   = 8'd0;
          state_next = (state == ST_PLUS_TEXT) ? ST_PLUS_LF : ST_FREE_LF;
        end else err = 1'b1;
      end
      ST_PLUS_NEXT: begin
        if (reply_mode == ModePlus && rx_byte == ChPlus) state_next = ST_PLUS;
        else if (reply_mode == ModePlus && rx_byte == ChCr) state_next = ST_BLANK_LF;
        else if (reply_mode == ModeSms && is_printable(rx_byte)) begin
          put_en     = 1'b1;
          state_next = ST_SMS_TEXT;
        end else err = 1'b1;
      end
      ST_BLANK_END, ST_FREE_END, ST_SMS_END: begin
        if (rx_byte == ChO) state_next = ST_O;
        else if (rx_byte == ChE) state_next = ST_E;
        else if (state == ST_SMS_END && rx_byte == ChPlus) state_next = ST_PLUS;
        else err = 1'b1;
      end
      ST_FREE_NEXT: begin
        if (rx_byte == ChCr) begin
          cur_base   = 8'd0;
          state_next = ST_FREE_CR_LF;
        end else err = 1'b1;
      end
      ST_SMS_TEXT: begin
        if (reply_mode == ModeSms && is_printable(rx_byte)) begin
          put_en = 1'b1;
        end else if (reply_mode == ModeSms && rx_byte == ChCr) begin
          cur_base   = 8'd0;
          lc_base    = sat_inc(text_lines);
          state_next = ST_SMS_LF;
        end else err = 1'b1;
      end
      ST_SMS_NEXT: begin
        if (rx_byte == ChCr) state_next = ST_SMS_CR_LF;
        else err = 1'b1;
      end
      default: begin
        state_next = ST_WAIT;
      end
    endcase

    cursor_next     = cur_base;
    text_lines_next = lc_base;

    if (put_en && ({1'b0, lc_base} < MaxLinesW)) begin
      res.store_line = lc_base[6:0];
      if ({1'b0, cur_base} < LineSizeW) begin
        res.store_column = cur_base[6:0];
        if (!put_space) begin
          res.store_count = StoreOne;
          res.store_char  = put_c;
        end else if (({1'b0, cur_base} + 9'd1) < LineSizeW) begin
          res.store_count = StoreSpace;
          res.store_char  = put_c;
        end else begin
          res.store_count = StoreOne;
          res.store_char  = ChSpace;
        end
      end
      cursor_next = put_space ? sat_inc(sat_inc(cur_base)) : sat_inc(cur_base);
    end

    if (state == ST_SMS_TEXT && put_en && ({1'b0, cursor_next} >= LineSizeW)) begin
      text_lines_next = sat_inc(lc_base);
      cursor_next     = 8'd0;
    end

    if (err) begin
      state_next       = ST_WAIT;
      res.parse_status = StatusError;
    end

    res.reply_outcome = outcome_next;
    res.lines_stored  = text_lines_next;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      reply_mode <= ModePlus;
      state      <= ST_WAIT;
      cursor     <= 8'd0;
      text_lines <= 8'd0;
      outcome    <= OutcomeProgress;
    end else begin
      if (cfg_write) reply_mode <= cfg_data;
      if (push) begin
        state      <= state_next;
        cursor     <= cursor_next;
        text_lines <= text_lines_next;
        outcome    <= outcome_next;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid  <= 1'b0;
      skid_valid <= 1'b0;
    end else if (!out_valid || pop) begin
      if (skid_valid) begin
        out_reg    <= skid_reg;
        out_valid  <= 1'b1;
        skid_valid <= 1'b0;
      end else begin
        if (push) out_reg <= res;
        out_valid <= push;
      end
    end else if (push) begin
      skid_reg   <= res;
      skid_valid <= 1'b1;
    end
  end

  assign parse_status  = out_reg.parse_status;
  assign reply_outcome = out_reg.reply_outcome;
  assign lines_stored  = out_reg.lines_stored;
  assign store_count   = out_reg.store_count;
  assign store_line    = out_reg.store_line;
  assign store_column  = out_reg.store_column;
  assign store_char    = out_reg.store_char;

  a_skid_behind_out: assert property (@(posedge clk) disable iff (rst)
    skid_valid |-> out_valid)
    else $error("second output entry holds a result while the first is empty");

  a_no_write_clean: assert property (@(posedge clk) disable iff (rst)
    (out_valid && store_count == StoreNone) |-> (store_column == 7'd0 && store_char == 8'd0))
    else $error("column or character set without a write");

  a_full_stalls: assert property (@(posedge clk) disable iff (rst)
    (out_valid && out_stall && push) |=> in_stall)
    else $error("input not stalled with both output entries full");

endmodule

FILE: tb/modem_response_parser_tb.sv
module modem_response_parser_tb;
  import mrp_pkg::*;

  typedef enum logic [4:0] {
    PS_WAIT       = 5'd0,
    PS_LEAD_LF    = 5'd1,
    PS_LINE_START = 5'd2,
    PS_GOT_O      = 5'd3,
    PS_GOT_E      = 5'd4,
    PS_PLUS       = 5'd5,
    PS_GOT_OK     = 5'd6,
    PS_OK_CR      = 5'd7,
    PS_GOT_ER     = 5'd9,
    PS_GOT_ERR    = 5'd10,
    PS_GOT_ERRO   = 5'd11,
    PS_GOT_ERROR  = 5'd12,
    PS_ERROR_CR   = 5'd13,
    PS_PLUS_TEXT  = 5'd15,
    PS_PLUS_LF    = 5'd16,
    PS_PLUS_NEXT  = 5'd17,
    PS_BLANK_LF   = 5'd18,
    PS_BLANK_END  = 5'd19,
    PS_FREE_TEXT  = 5'd20,
    PS_FREE_LF    = 5'd21,
    PS_FREE_NEXT  = 5'd22,
    PS_FREE_CR_LF = 5'd23,
    PS_FREE_END   = 5'd24,
    PS_SMS_TEXT   = 5'd25,
    PS_SMS_LF     = 5'd26,
    PS_SMS_NEXT   = 5'd27,
    PS_SMS_CR_LF  = 5'd28,
    PS_SMS_END    = 5'd29
  } parse_state_t;

  class reply_scoreboard;
    parse_state_t state;
    logic [1:0] mode;
    logic [1:0] outcome;
    logic [7:0] cursor;
    logic [7:0] lines;
    result_t cur;
    result_t pending_results[$];
    int noted;
    int checked;
    int errors;

    function new();
      state = PS_WAIT;
      mode = ModePlus;
      outcome = OutcomeProgress;
      cursor = '0;
      lines = '0;
      noted = 0;
      checked = 0;
      errors = 0;
    endfunction

    function logic is_text(logic [7:0] c);
      return c >= ChSpace && c <= ChLast;
    endfunction

    function logic [7:0] step_sat(logic [7:0] v);
      return (v == 8'hFF) ? v : v + 8'd1;
    endfunction

    function void store(logic [7:0] c, bit spaced);
      if (lines >= MaxLinesDefault) return;
      cur.store_line = lines[6:0];
      if (cursor < LineSizeDefault) begin
        cur.store_column = cursor[6:0];
        if (spaced && int'(cursor) + 1 >= LineSizeDefault) begin
          cur.store_count = StoreOne;
          cur.store_char = ChSpace;
        end else begin
          cur.store_count = spaced ? StoreSpace : StoreOne;
          cur.store_char = c;
        end
      end
      cursor = step_sat(cursor);
      if (spaced) cursor = step_sat(cursor);
    endfunction

    function void note_byte(logic [7:0] c);
      parse_state_t nx;
      logic [1:0] status;
      logic bad;
      cur = '0;
      nx = state;
      status = StatusPending;
      bad = 1'b0;
      case (state)
        PS_WAIT: begin
          outcome = OutcomeProgress;
          lines = '0;
          cursor = '0;
          if (c == ChCr) nx = PS_LEAD_LF; else bad = 1'b1;
        end
        PS_LEAD_LF, PS_PLUS_LF, PS_BLANK_LF, PS_FREE_LF, PS_FREE_CR_LF, PS_SMS_LF,
        PS_SMS_CR_LF: begin
          // Each line feed state is followed by the state one code higher.
          if (c == ChLf) nx = parse_state_t'(state + 5'd1); else bad = 1'b1;
        end
        PS_LINE_START: begin
          if (c == ChO) nx = PS_GOT_O;
          else if (c == ChE) nx = PS_GOT_E;
          else if (c == ChPlus && (mode == ModePlus || mode == ModeSms)) nx = PS_PLUS;
          else if (mode == ModeFree && is_text(c)) begin
            store(c, 0);
            nx = PS_FREE_TEXT;
          end else bad = 1'b1;
        end
        PS_GOT_O: if (c == ChK) nx = PS_GOT_OK; else bad = 1'b1;
        PS_GOT_E: if (c == ChR) nx = PS_GOT_ER; else bad = 1'b1;
        PS_PLUS: begin
          if (is_text(c)) begin
            store(c, 0);
            nx = PS_PLUS_TEXT;
          end else bad = 1'b1;
        end
        PS_GOT_OK: if (c == ChCr) nx = PS_OK_CR; else bad = 1'b1;
        PS_OK_CR: begin
          nx = PS_WAIT;
          if (c == ChLf) begin
            cursor = '0;
            outcome = OutcomeOk;
            status = StatusComplete;
          end else begin
            outcome = OutcomeError;
            status = StatusError;
          end
        end
        PS_GOT_ER: if (c == ChR) nx = PS_GOT_ERR; else bad = 1'b1;
        PS_GOT_ERR: if (c == ChO) nx = PS_GOT_ERRO; else bad = 1'b1;
        PS_GOT_ERRO: if (c == ChR) nx = PS_GOT_ERROR; else bad = 1'b1;
        PS_GOT_ERROR: if (c == ChCr) nx = PS_ERROR_CR; else bad = 1'b1;
        PS_ERROR_CR: begin
          if (c == ChLf) begin
            nx = PS_WAIT;
            cursor = '0;
            outcome = OutcomeError;
            status = StatusComplete;
          end else bad = 1'b1;
        end
        PS_PLUS_TEXT, PS_FREE_TEXT: begin
          if (is_text(c)) begin
            store(c, state == PS_PLUS_TEXT && mode == ModeSms && c == ChQuote);
          end else if (c == ChCr) begin
            lines = step_sat(lines);
            cursor = '0;
            nx = (state == PS_PLUS_TEXT) ? PS_PLUS_LF : PS_FREE_LF;
          end else bad = 1'b1;
        end
        PS_PLUS_NEXT: begin
          if (mode == ModePlus && c == ChPlus) nx = PS_PLUS;
          else if (mode == ModePlus && c == ChCr) nx = PS_BLANK_LF;
          else if (mode == ModeSms && is_text(c)) begin
            store(c, 0);
            nx = PS_SMS_TEXT;
          end else bad = 1'b1;
        end
        PS_BLANK_END, PS_FREE_END, PS_SMS_END: begin
          if (c == ChO) nx = PS_GOT_O;
          else if (c == ChE) nx = PS_GOT_E;
          else if (state == PS_SMS_END && c == ChPlus) nx = PS_PLUS;
          else bad = 1'b1;
        end
        PS_FREE_NEXT: begin
          if (c == ChCr) begin
            cursor = '0;
            nx = PS_FREE_CR_LF;
          end else bad = 1'b1;
        end
        PS_SMS_TEXT: begin
          if (mode == ModeSms && is_text(c)) begin
            store(c, 0);
            if (cursor >= LineSizeDefault) begin
              lines = step_sat(lines);
              cursor = '0;
            end
          end else if (mode == ModeSms && c == ChCr) begin
            cursor = '0;
            lines = step_sat(lines);
            nx = PS_SMS_LF;
          end else bad = 1'b1;
        end
        PS_SMS_NEXT: if (c == ChCr) nx = PS_SMS_CR_LF; else bad = 1'b1;
        default: nx = PS_WAIT;
      endcase
      if (bad) begin
        nx = PS_WAIT;
        status = StatusError;
      end
      state = nx;
      cur.parse_status = status;
      cur.reply_outcome = outcome;
      cur.lines_stored = lines;
      pending_results.push_back(cur);
      noted++;
    endfunction

    task report(string msg);
      errors++;
      if (errors <= 50) $display("tb: mismatch: %s", msg);
    endtask

    task compare_field(string name, int got, int want);
      if (got != want)
        report($sformatf("result %0d %s got %0d expected %0d", checked, name, got, want));
    endtask

    task check_result(result_t got);
      result_t want;
      if (pending_results.size() == 0) begin
        report("result transfer with no byte outstanding");
        return;
      end
      want = pending_results.pop_front();
      compare_field("parse_status", got.parse_status, want.parse_status);
      compare_field("reply_outcome", got.reply_outcome, want.reply_outcome);
      compare_field("lines_stored", got.lines_stored, want.lines_stored);
      compare_field("store_count", got.store_count, want.store_count);
      compare_field("store_line", got.store_line, want.store_line);
      compare_field("store_column", got.store_column, want.store_column);
      compare_field("store_char", got.store_char, want.store_char);
      checked++;
    endtask
  endclass

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic cfg_write = 1'b0;
  logic [1:0] cfg_data = 2'd0;
  logic in_valid = 1'b0;
  logic in_stall;
  logic [7:0] rx_byte = 8'd0;
  logic out_valid;
  logic out_stall = 1'b0;
  logic [1:0] parse_status;
  logic [1:0] reply_outcome;
  logic [7:0] lines_stored;
  logic [1:0] store_count;
  logic [6:0] store_line;
  logic [6:0] store_column;
  logic [7:0] store_char;
  result_t seen;

  reply_scoreboard board = new();
  int gap_pct = 8;
  logic [7:0] reply_q[$];

  modem_response_parser u_top (
    .clk(clk),
    .rst(rst),
    .cfg_write(cfg_write),
    .cfg_data(cfg_data),
    .in_valid(in_valid),
    .in_stall(in_stall),
    .rx_byte(rx_byte),
    .out_valid(out_valid),
    .out_stall(out_stall),
    .parse_status(parse_status),
    .reply_outcome(reply_outcome),
    .lines_stored(lines_stored),
    .store_count(store_count),
    .store_line(store_line),
    .store_column(store_column),
    .store_char(store_char)
  );

  assign seen = {parse_status, reply_outcome, lines_stored, store_count, store_line,
                 store_column, store_char};

  always #4 clk = ~clk;

  always @(negedge clk) begin
    out_stall <= ($urandom_range(0, 99) < gap_pct);
  end

  always @(posedge clk) begin
    if (!rst && out_valid && !out_stall) board.check_result(seen);
  end

  task automatic send_byte(input logic [7:0] b);
    while ($urandom_range(0, 99) < gap_pct) begin
      in_valid <= 1'b0;
      @(negedge clk);
    end
    in_valid <= 1'b1;
    rx_byte <= b;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    board.note_byte(b);
    @(negedge clk);
  endtask

  task automatic send_reply();
    foreach (reply_q[i]) send_byte(reply_q[i]);
  endtask

  task automatic drain();
    in_valid <= 1'b0;
    do @(negedge clk); while (board.pending_results.size() != 0);
  endtask

  task automatic write_mode(input logic [1:0] m);
    cfg_write <= 1'b1;
    cfg_data <= m;
    @(negedge clk);
    cfg_write <= 1'b0;
    board.mode = m;
  endtask

  function automatic logic [7:0] pick_char(int quote_pct);
    if ($urandom_range(0, 99) < quote_pct) return ChQuote;
    return 8'($urandom_range(ChSpace, ChLast));
  endfunction

  function automatic int text_len(int fixed_len);
    if (fixed_len != 0) return fixed_len;
    if ($urandom_range(0, 19) == 0) return $urandom_range(120, 135);
    return $urandom_range(1, 8);
  endfunction

  function automatic void add_text(int len, int quote_pct);
    for (int i = 0; i < len; i++) reply_q.push_back(pick_char(quote_pct));
  endfunction

  function automatic void build_reply(logic [1:0] shape, int n, int fixed_len, bit clean);
    logic [7:0] c;
    int r;
    reply_q = {};
    reply_q.push_back(ChCr);
    reply_q.push_back(ChLf);
    case (shape)
      ModePlus: begin
        for (int i = 0; i < n; i++) begin
          reply_q.push_back(ChPlus);
          add_text(text_len(fixed_len), 10);
          reply_q.push_back(ChCr);
          reply_q.push_back(ChLf);
        end
        if (n > 0) begin
          reply_q.push_back(ChCr);
          reply_q.push_back(ChLf);
        end
      end
      ModeFree: begin
        if (n > 0) begin
          c = pick_char(5);
          if (c == ChO || c == ChE) c = ChPlus;
          reply_q.push_back(c);
          add_text(text_len(fixed_len) - 1, 5);
          reply_q.push_back(ChCr);
          reply_q.push_back(ChLf);
          reply_q.push_back(ChCr);
          reply_q.push_back(ChLf);
        end
      end
      ModeSms: begin
        for (int i = 0; i < n; i++) begin
          reply_q.push_back(ChPlus);
          add_text(text_len(fixed_len), 25);
          reply_q.push_back(ChCr);
          reply_q.push_back(ChLf);
          add_text(text_len(fixed_len), 10);
          reply_q.push_back(ChCr);
          reply_q.push_back(ChLf);
          reply_q.push_back(ChCr);
          reply_q.push_back(ChLf);
        end
      end
      default: ;
    endcase
    if ($urandom_range(0, 3) == 0) begin
      reply_q.push_back(ChE);
      reply_q.push_back(ChR);
      reply_q.push_back(ChR);
      reply_q.push_back(ChO);
      reply_q.push_back(ChR);
    end else begin
      reply_q.push_back(ChO);
      reply_q.push_back(ChK);
    end
    reply_q.push_back(ChCr);
    reply_q.push_back(ChLf);
    if (clean) return;
    r = $urandom_range(0, 99);
    if (r < 10) reply_q[$urandom_range(0, reply_q.size() - 1)] = 8'($urandom_range(0, 255));
    else if (r < 14) reply_q[reply_q.size() - 1] = 8'($urandom_range(0, 255));
    else if (r < 18) reply_q = reply_q[0:$urandom_range(0, reply_q.size() - 1)];
  endfunction

  initial begin
    #4000000;
    $display("tb: failure");
    $finish;
  end

  initial begin
    logic [1:0] m;
    logic [1:0] shape;
    int n;
    repeat (7) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);

    write_mode(ModeSms);
    reply_q = '{8'hFF, ChCr, ChLf, ChE, ChR, ChR, ChO, ChR, ChCr, ChLf,
                ChCr, ChLf, ChPlus, ChSpace, ChQuote, ChCr, ChLf, ChLast, ChCr, ChLf,
                ChCr, ChLf, ChO, ChK, ChCr, 8'h00};
    send_reply();

    for (int phase = 0; phase < 6 || board.noted < 1450; phase++) begin
      drain();
      if (phase < 4) m = 2'(phase);
      else if ($urandom_range(0, 7) == 0) m = 2'd3;
      else m = 2'($urandom_range(0, 2));
      if (phase == 4) m = ModeSms;
      if (phase == 5) m = ModeFree;
      write_mode(m);
      gap_pct = (phase == 2) ? 0 : 8;
      if (phase == 4) begin
        build_reply(ModeSms, 66, 1, 1);
        send_reply();
      end else if (phase == 5) begin
        build_reply(ModeFree, 1, 260, 1);
        send_reply();
      end else begin
        repeat ($urandom_range(3, 6)) begin
          if ($urandom_range(0, 24) == 0) drain();
          if ($urandom_range(0, 99) < 8)
            repeat ($urandom_range(1, 3)) send_byte(8'($urandom_range(0, 255)));
          shape = ($urandom_range(0, 99) < 85) ? m : 2'($urandom_range(0, 3));
          if (shape == ModeFree) n = $urandom_range(0, 1);
          else if ($urandom_range(0, 99) == 0) n = $urandom_range(20, 40);
          else n = $urandom_range(0, 4);
          build_reply(shape, n, 0, 0);
          send_reply();
        end
      end
    end

    drain();
    repeat (8) @(negedge clk);
    if (board.errors == 0 && board.pending_results.size() == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

endmodule
